[src/cursor_line_edit_buffer_macros.svh]
// ============================================================================
// Assertion macros for the line edit buffer
// Shared concurrent assertion forms, clocked on i_clk.
// ============================================================================
`ifndef CURSOR_LINE_EDIT_BUFFER_MACROS_SVH
`define CURSOR_LINE_EDIT_BUFFER_MACROS_SVH

// property checked outside reset only
`define CLB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// property checked at every edge, reset included
`define CLB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[src/clb_pkg.sv]
// ============================================================================
// clb_pkg
// Command, status and cell control codes for the line edit buffer.
// ============================================================================
package clb_pkg;

    // command codes
    localparam logic [2:0] MODE_LEFT   = 3'd0;
    localparam logic [2:0] MODE_RIGHT  = 3'd1;
    localparam logic [2:0] MODE_BACK   = 3'd2;
    localparam logic [2:0] MODE_INSERT = 3'd3;
    localparam logic [2:0] MODE_READ   = 3'd4;

    // result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // per-cell text operation
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic [1:0] op;        // text operation
        logic       ld_rd;     // copy text into the read line
        logic       shift_rd;  // move the read line one cell towards cell 0
    } t_cell_ctrl;

endpackage

[src/clb_cell.sv]
// ============================================================================
// clb_cell
// One text position: holds a character and one stage of the read line.
// ============================================================================
module clb_cell
    import clb_pkg::*;
#(
    parameter int IDX = 0,
    parameter int PW  = 11
) (
    input  logic          i_clk,
    input  t_cell_ctrl    i_ctrl,
    input  logic [PW-1:0] i_pos,
    input  logic [7:0]    i_char,
    input  logic [7:0]    i_left_char,
    input  logic [7:0]    i_right_char,
    input  logic [7:0]    i_right_rd,
    output logic [7:0]    o_char,
    output logic [7:0]    o_rd
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [7:0] r_char;
    logic [7:0] r_rd;

    // text: open a gap on insert, close it on delete
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            CELL_INS: begin
                if (MY_IDX > i_pos) begin
                    r_char <= i_left_char;
                end else if (MY_IDX == i_pos) begin
                    r_char <= i_char;
                end
            end
            CELL_DEL: begin
                if (MY_IDX >= i_pos) begin
                    r_char <= i_right_char;
                end
            end
            default: begin
            end
        endcase
    end

    // read line: parallel load, then shift towards cell 0
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_rd) begin
            r_rd <= r_char;
        end else if (i_ctrl.shift_rd) begin
            r_rd <= i_right_rd;
        end
    end

    assign o_char = r_char;
    assign o_rd   = r_rd;

endmodule

[src/clb_chain.sv]
// ============================================================================
// clb_chain
// Row of text cells, each wired to its left and right neighbour.
// ============================================================================
module clb_chain
    import clb_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int PW       = 11
) (
    input  logic          i_clk,
    input  t_cell_ctrl    i_ctrl,
    input  logic [PW-1:0] i_pos,
    input  logic [7:0]    i_char,
    output logic [7:0]    o_rd0
);

    logic [7:0] w_char [CAPACITY];
    logic [7:0] w_rd   [CAPACITY];
    logic [7:0] w_lnb  [CAPACITY];
    logic [7:0] w_rnb  [CAPACITY];
    logic [7:0] w_rrd  [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        // neighbour wiring, ends of the row see zero
        if (g == 0) begin : g_first
            assign w_lnb[g] = 8'h00;
        end else begin : g_mid_l
            assign w_lnb[g] = w_char[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_rnb[g] = 8'h00;
            assign w_rrd[g] = 8'h00;
        end else begin : g_mid_r
            assign w_rnb[g] = w_char[g+1];
            assign w_rrd[g] = w_rd[g+1];
        end

        clb_cell #(
            .IDX (g),
            .PW  (PW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_pos        (i_pos),
            .i_char       (i_char),
            .i_left_char  (w_lnb[g]),
            .i_right_char (w_rnb[g]),
            .i_right_rd   (w_rrd[g]),
            .o_char       (w_char[g]),
            .o_rd         (w_rd[g])
        );
    end

    assign o_rd0 = w_rd[0];

endmodule

[src/cursor_line_edit_buffer.sv]
// ============================================================================
// cursor_line_edit_buffer
// Line edit text buffer with a cursor, held as a row of character cells.
// ============================================================================
//  Channel   Handshake          Fields
//  command   start / busy       i_mode, i_char_in, i_read_index
//  result    o_valid (strobe)   o_char_out, o_text_length,
//                               o_cursor_position, o_status
//
//  Move, backspace, insert and unused codes: busy stays low, result
//  strobed on the cycle after the command beat.
//  Read in range: the read line is loaded, then shifts one cell per
//  cycle towards cell 0, busy is high until the result is out.
//  Read out of range: handled like an edit command.
//  Synchronous active-low reset clears the counters; no clearing pass.
//  o_char_out and o_status are not held: present for the strobe cycle only.
// ============================================================================
module cursor_line_edit_buffer
    import clb_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_char_in,
    input  logic [9:0]  i_read_index,
    output logic        o_valid,
    output logic [7:0]  o_char_out,
    output logic [10:0] o_text_length,
    output logic [10:0] o_cursor_position,
    output logic [1:0]  o_status
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 10) ? CW : 10;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0] r_left,  n_left;
    logic [CW-1:0] r_right, n_right;
    logic          r_valid, n_valid;
    logic [7:0]    r_char_out, n_char_out;
    logic [1:0]    r_status, n_status;
    logic          r_rd_active, n_rd_active;
    logic [9:0]    r_rcnt, n_rcnt;

    logic          w_accept;
    logic [CW-1:0] w_len;
    logic [CW-1:0] w_pos;
    t_cell_ctrl    w_ctrl;
    logic [7:0]    w_rd0;

    assign w_accept = start && !r_rd_active;
    assign w_len    = r_left + r_right;

    // command decode and counter update
    always_comb begin
        n_left      = r_left;
        n_right     = r_right;
        n_valid     = 1'b0;
        n_char_out  = 8'h00;
        n_status    = ST_DONE;
        n_rd_active = r_rd_active;
        n_rcnt      = r_rcnt;
        w_pos       = r_left;
        w_ctrl      = '{op: CELL_HOLD, ld_rd: 1'b0, shift_rd: 1'b0};

        if (r_rd_active) begin
            // read in flight: walk the read line down to cell 0
            if (r_rcnt == 10'd0) begin
                n_valid     = 1'b1;
                n_char_out  = w_rd0;
                n_rd_active = 1'b0;
            end else begin
                w_ctrl.shift_rd = 1'b1;
                n_rcnt          = r_rcnt - 10'd1;
            end
        end else if (w_accept) begin
            n_valid = 1'b1;
            case (i_mode)
                MODE_LEFT: begin
                    if (r_left != '0) begin
                        n_left  = r_left - CW'(1);
                        n_right = r_right + CW'(1);
                    end else begin
                        n_status = ST_IGNORED;
                    end
                end
                MODE_RIGHT: begin
                    if (r_right != '0) begin
                        n_right = r_right - CW'(1);
                        n_left  = r_left + CW'(1);
                    end else begin
                        n_status = ST_IGNORED;
                    end
                end
                MODE_BACK: begin
                    if (r_left != '0) begin
                        n_left    = r_left - CW'(1);
                        w_pos     = r_left - CW'(1);
                        w_ctrl.op = CELL_DEL;
                    end else begin
                        n_status = ST_IGNORED;
                    end
                end
                MODE_INSERT: begin
                    if (w_len >= CAP_C) begin
                        n_status = ST_FULL;
                    end else begin
                        n_left    = r_left + CW'(1);
                        w_ctrl.op = CELL_INS;
                    end
                end
                MODE_READ: begin
                    if (CMPW'(i_read_index) < CMPW'(w_len)) begin
                        // result follows once the read line has shifted
                        n_valid      = 1'b0;
                        n_rd_active  = 1'b1;
                        n_rcnt       = i_read_index;
                        w_ctrl.ld_rd = 1'b1;
                    end else begin
                        n_status = ST_RANGE;
                    end
                end
                default: begin
                    n_status = ST_IGNORED;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_right     <= '0;
            r_valid     <= 1'b0;
            r_rd_active <= 1'b0;
        end else begin
            r_left      <= n_left;
            r_right     <= n_right;
            r_valid     <= n_valid;
            r_rd_active <= n_rd_active;
        end
    end

    // result payload and read countdown
    always_ff @(posedge i_clk) begin
        r_char_out <= n_char_out;
        r_status   <= n_status;
        r_rcnt     <= n_rcnt;
    end

    clb_chain #(
        .CAPACITY (CAPACITY),
        .PW       (CW)
    ) u_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_pos  (w_pos),
        .i_char (i_char_in),
        .o_rd0  (w_rd0)
    );

    assign busy              = r_rd_active;
    assign o_valid           = r_valid;
    assign o_char_out        = r_char_out;
    assign o_status          = r_status;
    assign o_text_length     = 11'(w_len);
    assign o_cursor_position = 11'(r_left);

endmodule

[src/clb_checker.sv]
// ============================================================================
// clb_checker
// Port-level checks on the line edit buffer, bound to the top level.
// ============================================================================
`include "cursor_line_edit_buffer_macros.svh"

module clb_checker
    import clb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  i_mode,
    input logic        o_valid,
    input logic [7:0]  o_char_out,
    input logic [1:0]  o_status
);

    // reset leaves nothing in flight
    `CLB_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !busy && !o_valid, "not idle after reset")

    // every non-read command beat gives its result on the next cycle
    `CLB_ASSERT(a_edit_result, start && !busy && i_mode != MODE_READ |=> o_valid, "edit result missing")

    // a result beat never overlaps a read in flight
    `CLB_ASSERT(a_valid_not_busy, o_valid |-> !busy, "result beat while busy")

    // failed commands report a zero character
    `CLB_ASSERT(a_err_char_zero, o_valid && o_status != ST_DONE |-> o_char_out == 8'h00, "character on failed command")

endmodule

bind cursor_line_edit_buffer clb_checker u_clb_checker (.*);
